/* design/jsp_pkg.sv */
// Shared types, constants and register codes for the Julia set point test.
package jsp_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int PT_W          = 32;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;
  localparam int LIMIT_W       = 8;
  localparam int MUL_LW        = 32;  // limb width of the shared multiplier

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_RE    = 8'd0,
    REG_SEED_IM    = 8'd1,
    REG_ITER_LIMIT = 8'd2
  } cfg_reg_t;

  localparam logic signed [PT_W-1:0]  SEED_RE_RST = -32'sd187904819;
  localparam logic signed [PT_W-1:0]  SEED_IM_RST = 32'sd72517838;
  localparam logic [LIMIT_W-1:0]      LIMIT_RST   = 8'd100;

  typedef struct packed {
    logic signed [PT_W-1:0] point_re;
    logic signed [PT_W-1:0] point_im;
  } in_word_t;

  typedef struct packed {
    logic in_set;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic signed [PT_W-1:0] seed_re;
    logic signed [PT_W-1:0] seed_im;
    logic [LIMIT_W-1:0]     iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic neg;
  } mul_ctl_t;

endpackage

/* design/jsp_stream_if.sv */
// Valid/ready channel carrying one word of a given type.
interface jsp_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/jsp_cfg_regs.sv */
// Configuration registers: seed and iteration limit.
module jsp_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  jsp_stream_if.sink    cfg_ch,
  output jsp_pkg::cfg_t cfg
);

  jsp_pkg::cfg_t cfg_r;
  jsp_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        jsp_pkg::REG_SEED_RE:    cfg_nxt.seed_re = cfg_ch.data.value;
        jsp_pkg::REG_SEED_IM:    cfg_nxt.seed_im = cfg_ch.data.value;
        jsp_pkg::REG_ITER_LIMIT:
          cfg_nxt.iteration_limit = cfg_ch.data.value[jsp_pkg::LIMIT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed_re         <= jsp_pkg::SEED_RE_RST;
      cfg_r.seed_im         <= jsp_pkg::SEED_IM_RST;
      cfg_r.iteration_limit <= jsp_pkg::LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* design/jsp_mul.sv */
// Shared limb-serial fixed-point multiplier: floor(+/- a*b / 2^FRAC_BITS).
module jsp_mul #(
  parameter int MW        = jsp_pkg::FRAC_BITS_DEF + 1,
  parameter int FRAC_BITS = jsp_pkg::FRAC_BITS_DEF,
  parameter int RW        = jsp_pkg::FRAC_BITS_DEF + 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  jsp_pkg::mul_ctl_t ctl,
  input  logic [MW-1:0]     a,
  input  logic [MW-1:0]     b,
  output logic              done,
  output logic signed [RW-1:0] prod
);

  localparam int LW  = jsp_pkg::MUL_LW;
  localparam int NL  = (MW + LW - 1) / LW;
  localparam int PW  = NL * LW;
  localparam int AW  = 2 * PW + 1;
  localparam int CW  = (NL > 1) ? $clog2(NL) : 1;
  localparam int SHW = $clog2(2 * NL);

  logic [PW-1:0]       a_r, a_nxt, b_r, b_nxt;
  logic                neg_r, neg_nxt;
  logic [CW-1:0]       i_r, i_nxt, j_r, j_nxt;
  logic                busy_r, busy_nxt;
  logic                pv_r, pv_nxt;
  logic [2*LW-1:0]     pp_r, pp_nxt;
  logic [SHW-1:0]      sh_r, sh_nxt;
  logic [AW-1:0]       acc_r, acc_nxt;
  logic                fin_r, fin_nxt;
  logic                done_r, done_nxt;
  logic signed [RW-1:0] prod_r, prod_nxt;
  logic [AW-1:0]       sval;

  assign done = done_r;
  assign prod = prod_r;
  assign sval = neg_r ? (~acc_r + {{(AW-1){1'b0}}, 1'b1}) : acc_r;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    neg_nxt  = neg_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    busy_nxt = busy_r;
    pp_nxt   = pp_r;
    sh_nxt   = sh_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    pv_nxt   = busy_r;
    fin_nxt  = pv_r && !busy_r;
    done_nxt = fin_r;

    if (ctl.start) begin
      a_nxt    = PW'(a);
      b_nxt    = PW'(b);
      neg_nxt  = ctl.neg;
      i_nxt    = '0;
      j_nxt    = '0;
      busy_nxt = 1'b1;
      acc_nxt  = '0;
    end

    // issue one limb product per cycle
    if (busy_r) begin
      pp_nxt = a_r[i_r*LW +: LW] * b_r[j_r*LW +: LW];
      sh_nxt = SHW'(i_r) + SHW'(j_r);
      if (j_r == CW'(NL - 1)) begin
        j_nxt = '0;
        if (i_r == CW'(NL - 1)) begin
          busy_nxt = 1'b0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end else begin
        j_nxt = j_r + 1'b1;
      end
    end

    if (pv_r) begin
      acc_nxt = acc_r + (AW'(pp_r) << (sh_r * LW));
    end

    // sign and floor shift
    if (fin_r) begin
      prod_nxt = sval[FRAC_BITS +: RW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pv_r   <= pv_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    neg_r  <= neg_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    pp_r   <= pp_nxt;
    sh_r   <= sh_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

endmodule

/* design/julia_set_point_test.sv */
// Top level: Julia set membership test of one complex point per word.
//
// Channels: in_ch takes a word {point_re, point_im}, signed fixed point with
// FRAC_BITS fraction bits (Q4.28 by default). out_ch returns one word
// {in_set} per input word: 1 when z = z*z + c stayed inside |z| < 2 for
// iteration_limit steps. cfg_ch writes seed_re (0), seed_im (1) and
// iteration_limit (2); other indexes are dropped. cfg_ch is always ready;
// write it only while no point is in flight.
//
// One limb-serial multiplier does all three products of an iteration
// (re*re, im*im, re*im), each over NL = ceil((FRAC_BITS+1)/32) limbs. A point
// that escapes early finishes early. in_ch.ready is high only while the
// sequencer is idle.
//
// The result sits in an output register, so the next point is accepted while
// the receiver stalls; a second finished result waits for that register.
// Reset (rst_n low, synchronous) restores the default seed -0.7 + 0.27015i,
// a limit of 100, and drops any point in flight and any pending result.
module julia_set_point_test #(
  parameter int FRAC_BITS = jsp_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  jsp_stream_if.sink   in_ch,
  jsp_stream_if.source out_ch,
  jsp_stream_if.sink   cfg_ch
);

  localparam int PT_W = jsp_pkg::PT_W;
  localparam int MW   = FRAC_BITS + 1;             // operand magnitude bits
  localparam int RW   = FRAC_BITS + 3;             // product bits, signed
  localparam int ZW   = ((FRAC_BITS + 3 > 31) ? FRAC_BITS + 3 : 31) + 2;

  localparam logic signed [ZW-1:0] TWO_FX  = {{(ZW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
  localparam logic [RW:0]          FOUR_FX = {{RW{1'b0}}, 1'b1} << (FRAC_BITS + 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAG,
    S_SQRE,
    S_SQIM,
    S_TEST,
    S_MULX,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic signed [ZW-1:0]   re_r, re_nxt, im_r, im_nxt;
  logic signed [RW-1:0]   sqre_r, sqre_nxt, sqim_r, sqim_nxt;
  logic [jsp_pkg::LIMIT_W-1:0] k_r, k_nxt;
  logic                   res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_set_r, out_set_nxt;
  jsp_pkg::mul_ctl_t      mul_ctl_r, mul_ctl_nxt;

  jsp_pkg::cfg_t          cfg;
  logic                   mul_done;
  logic signed [RW-1:0]   mul_prod;
  logic [MW-1:0]          mul_a, mul_b;

  logic signed [ZW-1:0]   re_abs, im_abs;
  logic                   esc_mag;
  logic [RW:0]            sq_sum;
  logic signed [ZW-1:0]   sqre_ext, sqim_ext, prod_ext, seed_re_ext, seed_im_ext;

  jsp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  jsp_mul #(
    .MW        (MW),
    .FRAC_BITS (FRAC_BITS),
    .RW        (RW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.data.in_set = out_set_r;

  // |re| >= 2 or |im| >= 2 escapes without any product
  assign esc_mag = (re_r >= TWO_FX) || (re_r <= -TWO_FX) ||
                   (im_r >= TWO_FX) || (im_r <= -TWO_FX);
  assign re_abs  = re_r[ZW-1] ? -re_r : re_r;
  assign im_abs  = im_r[ZW-1] ? -im_r : im_r;
  assign sq_sum  = {1'b0, sqre_r} + {1'b0, sqim_r};

  assign sqre_ext    = {{(ZW-RW){sqre_r[RW-1]}}, sqre_r};
  assign sqim_ext    = {{(ZW-RW){sqim_r[RW-1]}}, sqim_r};
  assign prod_ext    = {{(ZW-RW){mul_prod[RW-1]}}, mul_prod};
  assign seed_re_ext = {{(ZW-PT_W){cfg.seed_re[PT_W-1]}}, cfg.seed_re};
  assign seed_im_ext = {{(ZW-PT_W){cfg.seed_im[PT_W-1]}}, cfg.seed_im};

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      S_SQIM: begin
        mul_a = im_abs[MW-1:0];
        mul_b = im_abs[MW-1:0];
      end
      S_MULX: begin
        mul_a = re_abs[MW-1:0];
        mul_b = im_abs[MW-1:0];
      end
      default: begin
        mul_a = re_abs[MW-1:0];
        mul_b = re_abs[MW-1:0];
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    re_nxt        = re_r;
    im_nxt        = im_r;
    sqre_nxt      = sqre_r;
    sqim_nxt      = sqim_r;
    k_nxt         = k_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_set_nxt   = out_set_r;
    mul_ctl_nxt   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          re_nxt    = {{(ZW-PT_W){in_ch.data.point_re[PT_W-1]}}, in_ch.data.point_re};
          im_nxt    = {{(ZW-PT_W){in_ch.data.point_im[PT_W-1]}}, in_ch.data.point_im};
          k_nxt     = '0;
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        if (esc_mag) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          mul_ctl_nxt.start = 1'b1;
          state_nxt         = S_SQRE;
        end
      end
      S_SQRE: begin
        if (mul_done) begin
          sqre_nxt          = mul_prod;
          mul_ctl_nxt.start = 1'b1;
          state_nxt         = S_SQIM;
        end
      end
      S_SQIM: begin
        if (mul_done) begin
          sqim_nxt  = mul_prod;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (sq_sum >= FOUR_FX) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (k_r == cfg.iteration_limit) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mul_ctl_nxt.start = 1'b1;
          mul_ctl_nxt.neg   = re_r[ZW-1] ^ im_r[ZW-1];
          state_nxt         = S_MULX;
        end
      end
      S_MULX: begin
        // squares of this z are already in hand; finish z*z + c
        if (mul_done) begin
          re_nxt    = sqre_ext - sqim_ext + seed_re_ext;
          im_nxt    = (prod_ext <<< 1) + seed_im_ext;
          k_nxt     = k_r + 1'b1;
          state_nxt = S_MAG;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_set_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mul_ctl_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mul_ctl_r   <= mul_ctl_nxt;
    end
    re_r      <= re_nxt;
    im_r      <= im_nxt;
    sqre_r    <= sqre_nxt;
    sqim_r    <= sqim_nxt;
    k_r       <= k_nxt;
    res_r     <= res_nxt;
    out_set_r <= out_set_nxt;
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_SQRE || state_r == S_SQIM || state_r == S_MULX))
    else $error("multiplier finished outside a product wait state");

  a_start_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    mul_ctl_r.start |=> !mul_ctl_r.start)
    else $error("multiplier start held for more than one cycle");

  a_bounded_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRE || state_r == S_SQIM || state_r == S_MULX) |-> !esc_mag)
    else $error("multiplier running on an escaped point");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ch.ready) |=> (state_r == S_DONE))
    else $error("pending result overwritten while output stalled");

endmodule

/* tb/jsp_answer_check.sv */
`timescale 1ns / 1ps
// Checker for the Julia set point test: predicts each answer and compares it.
module jsp_answer_check #(
  parameter int FRAC_BITS = jsp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  jsp_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  jsp_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  jsp_pkg::cfg_word_t cfg_word,
  output int                 fail_count,
  output int                 owed_count,
  output int                 answered_count,
  output int                 bounded_count
);

  typedef struct {
    jsp_pkg::in_word_t point;
    logic              in_set;
  } owed_answer_t;

  owed_answer_t  owed_q[$];
  jsp_pkg::cfg_t live_cfg;

  // floor(a*b / 2^FRAC_BITS), exact over a double-width product
  function automatic longint fix_mul(longint a, longint b);
    logic signed [127:0] wa, wb, prod;
    wa   = a;
    wb   = b;
    prod = wa * wb;
    return longint'(prod >>> FRAC_BITS);
  endfunction

  // per-part bound first, then the floored |z|^2 >= 4 test
  function automatic bit escapes(longint re, longint im);
    longint two;
    two = longint'(2) <<< FRAC_BITS;
    if (re >= two || re <= -two || im >= two || im <= -two)
      return 1'b1;
    return (fix_mul(re, re) + fix_mul(im, im)) >= (longint'(4) <<< FRAC_BITS);
  endfunction

  function automatic logic predict_in_set(jsp_pkg::in_word_t pt, jsp_pkg::cfg_t cfg);
    longint re, im, next_re;
    bit     gone;
    re   = longint'($signed(pt.point_re));
    im   = longint'($signed(pt.point_im));
    gone = escapes(re, im);
    for (int k = 0; k < cfg.iteration_limit && !gone; k++) begin
      next_re = fix_mul(re, re) - fix_mul(im, im) + longint'($signed(cfg.seed_re));
      im      = 2 * fix_mul(re, im) + longint'($signed(cfg.seed_im));
      re      = next_re;
      gone    = escapes(re, im);
    end
    return !gone;
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] MISMATCH %s", $time, what);
  endfunction

  always @(posedge clk) begin : watch
    owed_answer_t head;
    owed_answer_t fresh;
    if (!rst_n) begin
      live_cfg       = '{seed_re: jsp_pkg::SEED_RE_RST, seed_im: jsp_pkg::SEED_IM_RST,
                         iteration_limit: jsp_pkg::LIMIT_RST};
      fail_count     = 0;
      answered_count = 0;
      bounded_count  = 0;
      owed_q.delete();
    end else begin
      // cfg is only written while idle, so predicting before the update is safe
      if (in_valid && in_ready) begin
        fresh.point  = in_word;
        fresh.in_set = predict_in_set(in_word, live_cfg);
        owed_q.insert(owed_q.size(), fresh);
      end
      if (out_valid && out_ready) begin
        answered_count++;
        if (owed_q.size() == 0) begin
          note_failure($sformatf("in_set=%0b arrived with no point owed", out_word.in_set));
        end else begin
          head = owed_q.pop_front();
          if (out_word.in_set !== head.in_set)
            note_failure($sformatf("point (%0d, %0d): expected in_set=%0b, got %0b",
                                   head.point.point_re, head.point.point_im,
                                   head.in_set, out_word.in_set));
          if (out_word.in_set === 1'b1)
            bounded_count++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_word.index)
          jsp_pkg::REG_SEED_RE:    live_cfg.seed_re = cfg_word.value;
          jsp_pkg::REG_SEED_IM:    live_cfg.seed_im = cfg_word.value;
          jsp_pkg::REG_ITER_LIMIT:
            live_cfg.iteration_limit = cfg_word.value[jsp_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
    owed_count = owed_q.size();
  end

endmodule

/* tb/tb_julia_set_point_test.sv */
`timescale 1ns / 1ps
// Testbench top: drives points and register writes, gives the verdict.
module tb_julia_set_point_test;

  localparam int PT_W       = jsp_pkg::PT_W;
  localparam int CFG_IDX_W  = jsp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = jsp_pkg::CFG_DATA_W;
  localparam int LIMIT_W    = jsp_pkg::LIMIT_W;

  // 2.0 in Q4.28 and the two neighbors of sqrt(2) that straddle |z|^2 == 4
  localparam logic signed [PT_W-1:0] FX_TWO     = 32'sh2000_0000;
  localparam logic signed [PT_W-1:0] FX_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [PT_W-1:0] FX_MIN     = 32'sh8000_0000;
  localparam logic signed [PT_W-1:0] ROOT2_DOWN = 32'sd379625062;
  localparam logic signed [PT_W-1:0] ROOT2_UP   = 32'sd379625063;
  localparam int                     DIRECTED_N = 13;

  // register indexes with no register behind them; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 8'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_LAST  = 8'hFF;

  // allow 5x the worst-case run, with every point running its full limit
  localparam longint RUN_LIMIT_NS = 40_000_000;

  logic clk;
  logic rst_n;

  jsp_stream_if #(.word_t(jsp_pkg::in_word_t))  in_ch  ();
  jsp_stream_if #(.word_t(jsp_pkg::out_word_t)) out_ch ();
  jsp_stream_if #(.word_t(jsp_pkg::cfg_word_t)) cfg_ch ();

  int fail_count, owed, answered, bounded;
  int points_sent    = 0;
  int settings_used  = 1;  // reset defaults count as the first setting
  int send_idle_pct  = 21;
  int recv_idle_pct  = 51;

  julia_set_point_test dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  jsp_answer_check answer_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_word        (in_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_word       (out_ch.data),
    .cfg_valid      (cfg_ch.valid),
    .cfg_ready      (cfg_ch.ready),
    .cfg_word       (cfg_ch.data),
    .fail_count     (fail_count),
    .owed_count     (owed),
    .answered_count (answered),
    .bounded_count  (bounded)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: stalls at the rate of the current idling mode, updated every cycle.
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Uniform value in [-half, +half], two's complement wrap does the sign.
  function automatic logic signed [PT_W-1:0] signed_span(int unsigned half);
    return $signed($urandom_range(2 * half, 0) - half);
  endfunction

  // Edges of the escape test: extremes, exactly 2.0, one LSB below, the
  // |z|^2 == 4 border away from the axes, and tiny negatives that floor.
  function automatic jsp_pkg::in_word_t directed_point(int k);
    jsp_pkg::in_word_t w;
    case (k)
      0:       w = '{point_re: '0,          point_im: '0};
      1:       w = '{point_re: FX_MAX,      point_im: FX_MAX};
      2:       w = '{point_re: FX_MIN,      point_im: FX_MIN};
      3:       w = '{point_re: FX_MAX,      point_im: FX_MIN};
      4:       w = '{point_re: FX_TWO,      point_im: '0};
      5:       w = '{point_re: FX_TWO - 1,  point_im: '0};
      6:       w = '{point_re: -FX_TWO,     point_im: '0};
      7:       w = '{point_re: '0,          point_im: -FX_TWO};
      8:       w = '{point_re: '0,          point_im: -FX_TWO + 1};
      9:       w = '{point_re: ROOT2_UP,    point_im: ROOT2_UP};
      10:      w = '{point_re: ROOT2_DOWN,  point_im: ROOT2_DOWN};
      11:      w = '{point_re: -ROOT2_DOWN, point_im: ROOT2_DOWN};
      default: w = '{point_re: -1,          point_im: -1};
    endcase
    return w;
  endfunction

  // Mostly points within |re|,|im| <= 2 so the iteration actually runs;
  // the rest full-range noise that mostly escapes before the first step.
  function automatic jsp_pkg::in_word_t random_point();
    jsp_pkg::in_word_t w;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      w.point_re = $urandom;
      w.point_im = $urandom;
    end else if (pick < 85) begin
      w.point_re = signed_span(32'h2000_0000);
      w.point_im = signed_span(32'h2000_0000);
    end else begin
      w.point_re = signed_span(32'h0800_0000);
      w.point_im = signed_span(32'h0800_0000);
    end
    return w;
  endfunction

  // One word on the input channel. valid stays high from the previous word
  // unless a gap is rolled, so it never drops and rises in one step.
  task automatic send_point(input jsp_pkg::in_word_t w);
    // idling mode follows progress: light sender gaps, then heavy, then none
    if (points_sent < 600) begin
      send_idle_pct = 21;
      recv_idle_pct = 51;
    end else if (points_sent < 1200) begin
      send_idle_pct = 51;
      recv_idle_pct = 21;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    points_sent++;
  endtask

  // Hold off the sender until every owed answer has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: value};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // New seed and limit, written only once the block has gone idle. The
  // limit word carries random upper bits, which the block must mask off.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] seed_re,
                               input logic [CFG_DATA_W-1:0] seed_im,
                               input logic [LIMIT_W-1:0]    limit);
    drain();
    write_reg(jsp_pkg::REG_SEED_RE, seed_re);
    write_reg(IDX_SPARE, $urandom);
    write_reg(jsp_pkg::REG_SEED_IM, seed_im);
    write_reg(jsp_pkg::REG_ITER_LIMIT, {24'($urandom), limit});
    write_reg(IDX_LAST, $urandom);
    settings_used++;
  endtask

  task automatic send_directed();
    for (int k = 0; k < DIRECTED_N; k++)
      send_point(directed_point(k));
  endtask

  // Random batch; halfway through the sender waits for the pipe to empty.
  task automatic send_batch(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        drain();
      send_point(random_point());
    end
  endtask

  initial begin : stimulus
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rst_n        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset seed -0.7 + 0.27015i, limit 100
    send_directed();
    send_batch(220);

    // zero limit: answer is the escape test of z0 alone; seeds at extremes
    apply_setting(FX_MAX, FX_MIN, 8'd0);
    send_directed();
    send_batch(150);

    // one step with a huge seed: anything still inside escapes on step one
    apply_setting(FX_MIN, FX_MAX, 8'd1);
    send_batch(150);

    // longest limit with c = 0: points in the unit disk run all 255 steps
    apply_setting('0, '0, 8'hFF);
    send_batch(16);

    // random seeds within +-2 (some within +-1), short random limits
    repeat (6) begin
      if ($urandom_range(1))
        apply_setting(signed_span(32'h2000_0000), signed_span(32'h2000_0000),
                      8'($urandom_range(24, 2)));
      else
        apply_setting(signed_span(32'h1000_0000), signed_span(32'h1000_0000),
                      8'($urandom_range(24, 2)));
      send_batch(200);
    end

    drain();
    // a short window after the last answer to catch stray results
    repeat (40) @(negedge clk);

    $display("Run covered %0d points under %0d seed/limit settings, incl. zero and max limit",
             points_sent, settings_used);
    $display("%0d answers checked: %0d bounded, %0d escaped; %0d mismatches",
             answered, bounded, answered - bounded, fail_count);
    if (fail_count == 0 && owed == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Timeout after %0d points sent, %0d answers still owed", points_sent, owed);
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
design/jsp_pkg.sv
design/jsp_stream_if.sv
design/jsp_cfg_regs.sv
design/jsp_mul.sv
design/julia_set_point_test.sv
tb/jsp_answer_check.sv
tb/tb_julia_set_point_test.sv
